// File: design/lpbr_pkg.sv
// Shared types, constants and state codes for the lidar polar bin reducer.
// Used by the divider, the core and the checkers; depends on nothing.
package lpbr_pkg;

   localparam int NUM_BINS    = 360;
   localparam int SEARCH_SPAN = 180;
   localparam int BIN_W       = 9;
   localparam int DIST_W      = 16;
   localparam int STEP_W      = 8;
   localparam int WORD_W      = DIST_W + 1;

   // Angle reduction: bias makes the angle positive, then a reciprocal multiply.
   localparam int ANG_W       = 17;
   localparam int MOD_BIAS    = 33120;
   localparam int RECIP       = 11651;
   localparam int RECIP_W     = 14;
   localparam int RECIP_SHIFT = 22;
   localparam int PROD_W      = ANG_W + RECIP_W;

   // Interpolation divider widths.
   localparam int DIV_NUM_W = 25;
   localparam int DIV_DEN_W = 9;
   localparam int DIV_CNT_W = 5;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_FINISH = 2'd1,
      KIND_READ   = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_MODE     = 2'd0,
      CSR_MIN_QUAL = 2'd1,
      CSR_RANGE    = 2'd2,
      CSR_FILL     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      RED_MAX    = 2'd0,
      RED_MIN    = 2'd1,
      RED_MEDIAN = 2'd2,
      RED_SPARE  = 2'd3
   } reducer_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_ADD_MUL, ST_ADD_MOD, ST_ADD_RD, ST_ADD_UPD,
      ST_RD_ISSUE, ST_RD_OUT, ST_FIL_RD, ST_FIL_CHK, ST_SL_RD, ST_SL_CHK,
      ST_SR_RD, ST_SR_CHK, ST_FIL_RES, ST_MUL1, ST_MUL2, ST_DIV_GO,
      ST_DIV_WAIT, ST_FIL_NEXT
   } state_type;

   typedef struct packed {
      kind_type              kind;
      logic [DIST_W-1:0]     point_dist;
      logic signed [15:0]    azimuth;
      logic [15:0]           quality;
      logic [BIN_W-1:0]      read_index;
   } req_type;

   typedef struct packed {
      logic [BIN_W-1:0]  bin_index;
      logic [DIST_W-1:0] bin_value;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: design/lpbr_bin_ram.sv
// Single-port bin memory with registered read data.
// Generic; no package dependency.
module lpbr_bin_ram #(
   parameter int DEPTH  = 360,
   parameter int ADDR_W = 9,
   parameter int DATA_W = 17
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];

   // One access per cycle: write or read at the same address.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

// File: design/lpbr_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on lpbr_pkg for widths and the request and response structs.
module lpbr_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  lpbr_pkg::div_req_type div_req,
   output lpbr_pkg::div_rsp_type div_rsp
);

   logic                           active_ff, active_in;
   logic [lpbr_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic [lpbr_pkg::DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [lpbr_pkg::DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [lpbr_pkg::DIV_DEN_W-1:0] den_ff, den_in;
   logic [lpbr_pkg::DIV_DEN_W:0]   trial;
   logic                           ge;

   // One shift-and-subtract step per cycle.
   always_comb begin
      trial     = {rem_ff, quo_ff[lpbr_pkg::DIV_NUM_W-1]};
      ge        = trial >= {1'b0, den_ff};
      active_in = active_ff;
      count_in  = count_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      if (div_req.start) begin
         active_in = 1'b1;
         count_in  = lpbr_pkg::DIV_CNT_W'(lpbr_pkg::DIV_NUM_W);
         quo_in    = div_req.dividend;
         rem_in    = '0;
         den_in    = div_req.divisor;
      end else if (active_ff) begin
         if (count_ff == '0) begin
            active_in = 1'b0;
         end else begin
            count_in = count_ff - 1'b1;
            quo_in   = {quo_ff[lpbr_pkg::DIV_NUM_W-2:0], ge};
            rem_in   = ge ? lpbr_pkg::DIV_DEN_W'(trial - {1'b0, den_ff})
                          : lpbr_pkg::DIV_DEN_W'(trial);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // The quotient is complete once every step has run.
   assign div_rsp.done     = active_ff && (count_ff == '0);
   assign div_rsp.quotient = quo_ff;

endmodule

// File: design/lidar_polar_bin_reducer_core.sv
// Top level of the lidar polar bin reducer: sequencer, configuration registers,
// bin memory and interpolation divider. Depends on lpbr_pkg, lpbr_bin_ram, lpbr_divider.
// Add: multiply, modulo, bin read and update states. Read: memory read, then the result strobe.
// Finish with gap fill visits every bin: an empty one is searched left, then right, and is
// copied or interpolated, through the single memory port and the bit-serial divider.
// One item at a time; results cannot be stalled. Reset runs a clearing pass over all bins.
module lidar_polar_bin_reducer_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lpbr_pkg::req_type req_data,
   output logic              rsp_valid,
   output lpbr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   lpbr_pkg::state_type state_ff, state_in;
   lpbr_pkg::req_type   req_ff, req_in;

   logic [1:0]  mode_ff;
   logic [15:0] minq_ff;
   logic [15:0] rlim_ff;
   logic        fill_ff;

   logic [lpbr_pkg::BIN_W-1:0]    ptr_ff, ptr_in;
   logic [lpbr_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [lpbr_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [lpbr_pkg::BIN_W-1:0]    bin_ff, bin_in;
   logic [lpbr_pkg::DIST_W-1:0]   lval_ff, lval_in, rval_ff, rval_in;
   logic [lpbr_pkg::STEP_W-1:0]   ldl_ff, ldl_in, rdr_ff, rdr_in;
   logic                          lfound_ff, lfound_in, rfound_ff, rfound_in;
   logic                          seen_ff, seen_in;
   logic [lpbr_pkg::DIV_NUM_W-1:0] acc_ff, acc_in;

   logic                          ram_we;
   logic [lpbr_pkg::BIN_W-1:0]    ram_addr;
   logic [lpbr_pkg::WORD_W-1:0]   ram_wdata, ram_rdata;
   logic [lpbr_pkg::DIST_W-1:0]   rd_dist;
   logic                          rd_seen;

   lpbr_pkg::div_req_type div_req;
   lpbr_pkg::div_rsp_type div_rsp;

   logic                          accept, drop, last_bin, last_step, rd_nonzero;
   logic [lpbr_pkg::ANG_W-1:0]    ang_u;
   logic [lpbr_pkg::ANG_W-1:0]    ang_rem;
   logic [lpbr_pkg::BIN_W:0]      left_diff, right_sum;
   logic [lpbr_pkg::BIN_W-1:0]    left_addr, right_addr;
   logic [lpbr_pkg::DIST_W:0]     mid_sum;
   logic [lpbr_pkg::DIST_W-1:0]   upd_dist;

   lpbr_bin_ram #(
      .DEPTH  (lpbr_pkg::NUM_BINS),
      .ADDR_W (lpbr_pkg::BIN_W),
      .DATA_W (lpbr_pkg::WORD_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   lpbr_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rd_dist    = ram_rdata[lpbr_pkg::DIST_W-1:0];
   assign rd_seen    = ram_rdata[lpbr_pkg::DIST_W];
   assign rd_nonzero = rd_dist != '0;
   assign busy       = state_ff != lpbr_pkg::ST_IDLE;
   assign accept     = start && !busy;
   assign last_bin   = ptr_ff == lpbr_pkg::BIN_W'(lpbr_pkg::NUM_BINS - 1);
   assign last_step  = step_ff == lpbr_pkg::STEP_W'(lpbr_pkg::SEARCH_SPAN - 1);
   assign csr_ready  = 1'b1;

   // Point filter on quality and on the optional range limit.
   assign drop = (req_data.quality < minq_ff) ||
                 ((rlim_ff != '0) && (req_data.point_dist > rlim_ff));

   // Biased angle and remainder after the reciprocal quotient.
   assign ang_u   = lpbr_pkg::ANG_W'($signed({req_ff.azimuth[15], req_ff.azimuth}))
                    + lpbr_pkg::ANG_W'(lpbr_pkg::MOD_BIAS);
   assign ang_rem = ang_u - lpbr_pkg::ANG_W'(
                    prod_ff[lpbr_pkg::PROD_W-1:lpbr_pkg::RECIP_SHIFT] * lpbr_pkg::NUM_BINS);

   // Circular neighbor addresses for the gap search.
   always_comb begin
      left_diff = {1'b0, ptr_ff} - {2'b0, step_ff};
      if (left_diff[lpbr_pkg::BIN_W]) begin
         left_diff = left_diff + (lpbr_pkg::BIN_W+1)'(lpbr_pkg::NUM_BINS);
      end
      left_addr = left_diff[lpbr_pkg::BIN_W-1:0];
      right_sum = {1'b0, ptr_ff} + {2'b0, step_ff};
      if (right_sum >= (lpbr_pkg::BIN_W+1)'(lpbr_pkg::NUM_BINS)) begin
         right_sum = right_sum - (lpbr_pkg::BIN_W+1)'(lpbr_pkg::NUM_BINS);
      end
      right_addr = right_sum[lpbr_pkg::BIN_W-1:0];
   end

   // Bin reduction of a kept point against the stored value.
   always_comb begin
      mid_sum  = {1'b0, rd_dist} + {1'b0, req_ff.point_dist};
      upd_dist = rd_dist;
      case (lpbr_pkg::reducer_type'(mode_ff))
         lpbr_pkg::RED_MIN: begin
            if (!rd_seen || (req_ff.point_dist < rd_dist)) upd_dist = req_ff.point_dist;
         end
         lpbr_pkg::RED_MEDIAN: begin
            if (!rd_seen) upd_dist = req_ff.point_dist;
            else if (req_ff.point_dist < rd_dist) upd_dist = mid_sum[lpbr_pkg::DIST_W:1];
         end
         default: begin
            if (req_ff.point_dist > rd_dist) upd_dist = req_ff.point_dist;
         end
      endcase
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpbr_pkg::ST_CLEAR:    if (last_bin) state_in = lpbr_pkg::ST_IDLE;
         lpbr_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.kind)
                  lpbr_pkg::KIND_ADD:    state_in = drop ? lpbr_pkg::ST_IDLE
                                                         : lpbr_pkg::ST_ADD_MUL;
                  lpbr_pkg::KIND_FINISH: state_in = fill_ff ? lpbr_pkg::ST_FIL_RD
                                                            : lpbr_pkg::ST_IDLE;
                  lpbr_pkg::KIND_READ:   state_in = lpbr_pkg::ST_RD_ISSUE;
                  lpbr_pkg::KIND_CLEAR:  state_in = lpbr_pkg::ST_CLEAR;
                  default:               state_in = lpbr_pkg::ST_IDLE;
               endcase
            end
         end
         lpbr_pkg::ST_ADD_MUL:  state_in = lpbr_pkg::ST_ADD_MOD;
         lpbr_pkg::ST_ADD_MOD:  state_in = lpbr_pkg::ST_ADD_RD;
         lpbr_pkg::ST_ADD_RD:   state_in = lpbr_pkg::ST_ADD_UPD;
         lpbr_pkg::ST_ADD_UPD:  state_in = lpbr_pkg::ST_IDLE;
         lpbr_pkg::ST_RD_ISSUE: state_in = lpbr_pkg::ST_RD_OUT;
         lpbr_pkg::ST_RD_OUT:   state_in = lpbr_pkg::ST_IDLE;
         lpbr_pkg::ST_FIL_RD:   state_in = lpbr_pkg::ST_FIL_CHK;
         lpbr_pkg::ST_FIL_CHK:  state_in = rd_nonzero ? lpbr_pkg::ST_FIL_NEXT
                                                      : lpbr_pkg::ST_SL_RD;
         lpbr_pkg::ST_SL_RD:    state_in = lpbr_pkg::ST_SL_CHK;
         lpbr_pkg::ST_SL_CHK:   state_in = (rd_nonzero || last_step) ? lpbr_pkg::ST_SR_RD
                                                                     : lpbr_pkg::ST_SL_RD;
         lpbr_pkg::ST_SR_RD:    state_in = lpbr_pkg::ST_SR_CHK;
         lpbr_pkg::ST_SR_CHK:   state_in = (rd_nonzero || last_step) ? lpbr_pkg::ST_FIL_RES
                                                                     : lpbr_pkg::ST_SR_RD;
         lpbr_pkg::ST_FIL_RES:  state_in = (lfound_ff && rfound_ff) ? lpbr_pkg::ST_MUL1
                                                                    : lpbr_pkg::ST_FIL_NEXT;
         lpbr_pkg::ST_MUL1:     state_in = lpbr_pkg::ST_MUL2;
         lpbr_pkg::ST_MUL2:     state_in = lpbr_pkg::ST_DIV_GO;
         lpbr_pkg::ST_DIV_GO:   state_in = lpbr_pkg::ST_DIV_WAIT;
         lpbr_pkg::ST_DIV_WAIT: if (div_rsp.done) state_in = lpbr_pkg::ST_FIL_NEXT;
         lpbr_pkg::ST_FIL_NEXT: state_in = last_bin ? lpbr_pkg::ST_IDLE : lpbr_pkg::ST_FIL_RD;
         default:               state_in = lpbr_pkg::ST_IDLE;
      endcase
   end

   // Output and datapath logic of the sequencer.
   always_comb begin
      req_in    = req_ff;
      ptr_in    = ptr_ff;
      step_in   = step_ff;
      prod_in   = prod_ff;
      bin_in    = bin_ff;
      lval_in   = lval_ff;
      rval_in   = rval_ff;
      ldl_in    = ldl_ff;
      rdr_in    = rdr_ff;
      lfound_in = lfound_ff;
      rfound_in = rfound_ff;
      seen_in   = seen_ff;
      acc_in    = acc_ff;
      ram_we    = 1'b0;
      ram_addr  = ptr_ff;
      ram_wdata = '0;
      div_req   = '0;
      rsp_valid = 1'b0;
      rsp_data.bin_index = req_ff.read_index;
      rsp_data.bin_value = '0;
      unique case (state_ff)
         lpbr_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            ptr_in = last_bin ? '0 : ptr_ff + 1'b1;
         end
         lpbr_pkg::ST_IDLE: begin
            ptr_in = '0;
            if (accept) req_in = req_data;
         end
         lpbr_pkg::ST_ADD_MUL: begin
            prod_in = lpbr_pkg::PROD_W'(ang_u * lpbr_pkg::RECIP_W'(lpbr_pkg::RECIP));
         end
         lpbr_pkg::ST_ADD_MOD: begin
            bin_in = ang_rem[lpbr_pkg::BIN_W-1:0];
         end
         lpbr_pkg::ST_ADD_RD: begin
            ram_addr = bin_ff;
         end
         lpbr_pkg::ST_ADD_UPD: begin
            ram_addr  = bin_ff;
            ram_we    = 1'b1;
            ram_wdata = {1'b1, upd_dist};
         end
         lpbr_pkg::ST_RD_ISSUE: begin
            ram_addr = (req_ff.read_index < lpbr_pkg::BIN_W'(lpbr_pkg::NUM_BINS))
                       ? req_ff.read_index : '0;
         end
         lpbr_pkg::ST_RD_OUT: begin
            rsp_valid = 1'b1;
            if (req_ff.read_index < lpbr_pkg::BIN_W'(lpbr_pkg::NUM_BINS)) begin
               rsp_data.bin_value = rd_dist;
            end
         end
         lpbr_pkg::ST_FIL_RD: begin
            ram_addr = ptr_ff;
         end
         lpbr_pkg::ST_FIL_CHK: begin
            seen_in   = rd_seen;
            step_in   = lpbr_pkg::STEP_W'(1);
            lfound_in = 1'b0;
            rfound_in = 1'b0;
         end
         lpbr_pkg::ST_SL_RD: begin
            ram_addr = left_addr;
         end
         lpbr_pkg::ST_SL_CHK: begin
            if (rd_nonzero) begin
               lfound_in = 1'b1;
               lval_in   = rd_dist;
               ldl_in    = step_ff;
            end
            step_in = (rd_nonzero || last_step) ? lpbr_pkg::STEP_W'(1) : step_ff + 1'b1;
         end
         lpbr_pkg::ST_SR_RD: begin
            ram_addr = right_addr;
         end
         lpbr_pkg::ST_SR_CHK: begin
            if (rd_nonzero) begin
               rfound_in = 1'b1;
               rval_in   = rd_dist;
               rdr_in    = step_ff;
            end
            step_in = step_ff + 1'b1;
         end
         lpbr_pkg::ST_FIL_RES: begin
            // A one-sided hit is copied; no hit leaves the bin empty.
            if (lfound_ff && !rfound_ff) begin
               ram_we    = 1'b1;
               ram_wdata = {seen_ff, lval_ff};
            end else if (rfound_ff && !lfound_ff) begin
               ram_we    = 1'b1;
               ram_wdata = {seen_ff, rval_ff};
            end
         end
         lpbr_pkg::ST_MUL1: begin
            acc_in = lpbr_pkg::DIV_NUM_W'(lval_ff * rdr_ff);
         end
         lpbr_pkg::ST_MUL2: begin
            acc_in = acc_ff + lpbr_pkg::DIV_NUM_W'(rval_ff * ldl_ff);
         end
         lpbr_pkg::ST_DIV_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = acc_ff;
            div_req.divisor  = {1'b0, ldl_ff} + {1'b0, rdr_ff};
         end
         lpbr_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               ram_we    = 1'b1;
               ram_wdata = {seen_ff, div_rsp.quotient[lpbr_pkg::DIST_W-1:0]};
            end
         end
         lpbr_pkg::ST_FIL_NEXT: begin
            ptr_in = last_bin ? '0 : ptr_ff + 1'b1;
         end
         default: begin
            ptr_in = '0;
         end
      endcase
   end

   // Sequencer and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpbr_pkg::ST_CLEAR;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
      end
      req_ff    <= req_in;
      step_ff   <= step_in;
      prod_ff   <= prod_in;
      bin_ff    <= bin_in;
      lval_ff   <= lval_in;
      rval_ff   <= rval_in;
      ldl_ff    <= ldl_in;
      rdr_ff    <= rdr_in;
      lfound_ff <= lfound_in;
      rfound_ff <= rfound_in;
      seen_ff   <= seen_in;
      acc_ff    <= acc_in;
   end

   // Configuration registers, written on each csr transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         minq_ff <= '0;
         rlim_ff <= '0;
         fill_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (lpbr_pkg::csr_index_type'(csr_index))
            lpbr_pkg::CSR_MODE:     mode_ff <= csr_wdata[1:0];
            lpbr_pkg::CSR_MIN_QUAL: minq_ff <= csr_wdata;
            lpbr_pkg::CSR_RANGE:    rlim_ff <= csr_wdata;
            lpbr_pkg::CSR_FILL:     fill_ff <= csr_wdata[0];
            default:                mode_ff <= mode_ff;
         endcase
      end
   end

endmodule

// File: design/lpbr_checker.sv
// Port-level assertions for the lidar polar bin reducer, with its bind.
// Depends on lpbr_pkg and lidar_polar_bin_reducer_core.
module lpbr_port_props (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input lpbr_pkg::req_type req_data,
   input logic              rsp_valid,
   input lpbr_pkg::rsp_type rsp_data
);

   // Reset starts the clearing pass, so the block is busy right after it.
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("block not busy after reset");

   // A result strobe lasts one cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // A result follows a read transfer through the issue and output states and echoes its index.
   a_read_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start && !busy, 2) &&
                     $past(req_data.kind, 2) == lpbr_pkg::KIND_READ &&
                     $past(req_data.read_index, 2) == rsp_data.bin_index))
      else $error("result without matching read transfer");

   // An index past the last bin reads as empty.
   a_oob_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bin_index >= lpbr_pkg::BIN_W'(lpbr_pkg::NUM_BINS))
      |-> rsp_data.bin_value == '0)
      else $error("out-of-range read returned data");

endmodule

bind lidar_polar_bin_reducer_core lpbr_port_props u_lpbr_port_props (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// File: verif/lpbr_checker.sv
// Checker for the lidar polar bin reducer: watches the request, result and
// register channels, predicts every bin read and compares. Depends on lpbr_pkg.
module lpbr_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  lpbr_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  lpbr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   output int                pending_reads,
   output int                mismatch_total
);

   // Predicted configuration and bin memory.
   lpbr_pkg::reducer_type       mode_q;
   logic [15:0]                 min_qual_q;
   logic [15:0]                 range_q;
   logic                        fill_q;
   logic [lpbr_pkg::DIST_W-1:0] bin_dist [lpbr_pkg::NUM_BINS];
   logic                        bin_seen [lpbr_pkg::NUM_BINS];
   lpbr_pkg::rsp_type           read_queue [$];

   function automatic int wrap_bin(int value);
      return ((value % lpbr_pkg::NUM_BINS) + lpbr_pkg::NUM_BINS) % lpbr_pkg::NUM_BINS;
   endfunction

   // Fold one point into its bin with the selected reducer.
   function automatic void fold_point(lpbr_pkg::req_type item);
      int          b;
      logic [16:0] sum;
      if (item.quality < min_qual_q) return;
      if (range_q != 0 && item.point_dist > range_q) return;
      b = wrap_bin(int'(item.azimuth));
      sum = bin_dist[b] + item.point_dist;
      case (mode_q)
         lpbr_pkg::RED_MIN: begin
            if (!bin_seen[b] || item.point_dist < bin_dist[b]) bin_dist[b] = item.point_dist;
         end
         lpbr_pkg::RED_MEDIAN: begin
            if (!bin_seen[b]) bin_dist[b] = item.point_dist;
            else if (item.point_dist < bin_dist[b]) bin_dist[b] = sum[16:1];
         end
         default: begin
            if (item.point_dist > bin_dist[b]) bin_dist[b] = item.point_dist;
         end
      endcase
      bin_seen[b] = 1'b1;
   endfunction

   // Fill empty bins in ascending order; earlier fills count for later bins.
   function automatic void fill_empty_bins();
      int          left, right, idx;
      longint      num;
      for (int a = 0; a < lpbr_pkg::NUM_BINS; a++) begin
         if (bin_dist[a] != 0) continue;
         left = -1;
         right = -1;
         for (int i = 1; i < lpbr_pkg::SEARCH_SPAN; i++) begin
            idx = wrap_bin(a - i);
            if (bin_dist[idx] != 0) begin left = i; break; end
         end
         for (int i = 1; i < lpbr_pkg::SEARCH_SPAN; i++) begin
            idx = wrap_bin(a + i);
            if (bin_dist[idx] != 0) begin right = i; break; end
         end
         if (left > 0 && right > 0) begin
            num = longint'(bin_dist[wrap_bin(a - left)]) * right
                + longint'(bin_dist[wrap_bin(a + right)]) * left;
            bin_dist[a] = lpbr_pkg::DIST_W'(num / (left + right));
         end else if (left > 0) begin
            bin_dist[a] = bin_dist[wrap_bin(a - left)];
         end else if (right > 0) begin
            bin_dist[a] = bin_dist[wrap_bin(a + right)];
         end
      end
   endfunction

   always @(posedge clock) begin
      lpbr_pkg::rsp_type want;
      int                errs;
      errs = 0;
      if (reset) begin
         mode_q     <= lpbr_pkg::RED_MAX;
         min_qual_q <= '0;
         range_q    <= '0;
         fill_q     <= 1'b0;
         for (int i = 0; i < lpbr_pkg::NUM_BINS; i++) begin
            bin_dist[i] = '0;
            bin_seen[i] = 1'b0;
         end
         read_queue.delete();
         mismatch_total <= 0;
      end else begin
         // Compare each result transfer with the oldest predicted read.
         if (rsp_valid) begin
            if (read_queue.size() == 0) begin
               $error("unexpected result: bin_index %0d bin_value %0d",
                      rsp_data.bin_index, rsp_data.bin_value);
               errs++;
            end else begin
               want = read_queue.pop_front();
               if (rsp_data.bin_index !== want.bin_index) begin
                  $error("bin_index: expected %0d, actual %0d",
                         want.bin_index, rsp_data.bin_index);
                  errs++;
               end
               if (rsp_data.bin_value !== want.bin_value) begin
                  $error("bin_value: expected %0d, actual %0d",
                         want.bin_value, rsp_data.bin_value);
                  errs++;
               end
            end
         end
         // Register write transfer.
         if (csr_valid && csr_ready) begin
            case (lpbr_pkg::csr_index_type'(csr_index))
               lpbr_pkg::CSR_MODE:     mode_q     <= lpbr_pkg::reducer_type'(csr_wdata[1:0]);
               lpbr_pkg::CSR_MIN_QUAL: min_qual_q <= csr_wdata;
               lpbr_pkg::CSR_RANGE:    range_q    <= csr_wdata;
               lpbr_pkg::CSR_FILL:     fill_q     <= csr_wdata[0];
            endcase
         end
         // Request transfer.
         if (start && !busy) begin
            case (req_data.kind)
               lpbr_pkg::KIND_ADD:    fold_point(req_data);
               lpbr_pkg::KIND_FINISH: if (fill_q) fill_empty_bins();
               lpbr_pkg::KIND_READ: begin
                  want.bin_index = req_data.read_index;
                  want.bin_value = (req_data.read_index < lpbr_pkg::NUM_BINS) ?
                                   bin_dist[req_data.read_index] : '0;
                  read_queue.push_back(want);
               end
               default: begin
                  for (int i = 0; i < lpbr_pkg::NUM_BINS; i++) begin
                     bin_dist[i] = '0;
                     bin_seen[i] = 1'b0;
                  end
               end
            endcase
         end
         mismatch_total <= mismatch_total + errs;
      end
      pending_reads = read_queue.size();
   end

endmodule

// File: verif/tb.sv
// Testbench top for the lidar polar bin reducer: clock, reset, stimulus and
// verdict. Depends on lpbr_pkg, lidar_polar_bin_reducer_core and lpbr_checker.
module tb;

   localparam int CYCLE_LIMIT = 3000000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   lpbr_pkg::req_type req_data;
   logic    rsp_valid;
   lpbr_pkg::rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;
   int      pending_reads;
   int      mismatch_total;
   int      cycle_count = 0;
   logic    no_gaps;
   logic [15:0] cur_range;

   lidar_polar_bin_reducer_core dut (.*);

   lpbr_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run-length guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Random gap length: mostly short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Present one request and hold it until the block takes the transfer.
   task automatic send_item(lpbr_pkg::kind_type kind, logic [15:0] point_dist,
                            logic [15:0] angle, logic [15:0] qual, logic [8:0] index);
      int gap;
      req_data.kind        = kind;
      req_data.point_dist  = point_dist;
      req_data.azimuth     = angle;
      req_data.quality     = qual;
      req_data.read_index  = index;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Let the block drain completely, including work that gives no result.
   task automatic wait_idle();
      start = 1'b0;
      while (pending_reads != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Register write transfer while the block is idle.
   task automatic write_reg(lpbr_pkg::csr_index_type index, logic [15:0] value);
      wait_idle();
      csr_index = index;
      csr_wdata = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      if (index == lpbr_pkg::CSR_RANGE) cur_range = value;
   endtask

   task automatic random_add();
      logic [15:0] angle, range_val;
      angle     = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 719));
      range_val = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 4000));
      send_item(lpbr_pkg::KIND_ADD, range_val, angle, 16'($urandom), 9'd0);
   endtask

   task automatic random_read();
      logic [8:0] index;
      index = $urandom_range(0, 9) == 0 ? 9'($urandom) : 9'($urandom_range(0, 359));
      send_item(lpbr_pkg::KIND_READ, '0, '0, '0, index);
   endtask

   // One frame: fresh bins, one point that is always kept, then mixed traffic.
   task automatic run_frame(int items);
      int r;
      send_item(lpbr_pkg::KIND_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                9'($urandom));
      send_item(lpbr_pkg::KIND_ADD, cur_range == 0 ? 16'd1000 : cur_range,
                16'($urandom), 16'hFFFF, 9'd0);
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 68) random_add();
         else if (r < 95) random_read();
         else send_item(lpbr_pkg::KIND_FINISH, 16'($urandom), 16'($urandom),
                        16'($urandom), '0);
      end
      // Sweep a few bins after a final finish.
      send_item(lpbr_pkg::KIND_FINISH, '0, '0, '0, '0);
      repeat (6) random_read();
   endtask

   initial begin
      int  frames;
      no_gaps   = 1'b0;
      cur_range = '0;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset     = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reads of empty bins, out-of-range index, angle and field extremes.
      send_item(lpbr_pkg::KIND_READ, '0, '0, '0, 9'd0);
      send_item(lpbr_pkg::KIND_READ, '0, '0, '0, 9'd359);
      send_item(lpbr_pkg::KIND_READ, '0, '0, '0, 9'd511);
      send_item(lpbr_pkg::KIND_ADD, 16'hFFFF, 16'h8000, 16'd0, 9'd0);
      send_item(lpbr_pkg::KIND_ADD, 16'd0, 16'h7FFF, 16'hFFFF, 9'd0);
      send_item(lpbr_pkg::KIND_ADD, 16'd500, 16'hFFFF, 16'd1, 9'd0);
      send_item(lpbr_pkg::KIND_ADD, 16'd700, 16'd360, 16'd1, 9'd0);
      send_item(lpbr_pkg::KIND_ADD, 16'd300, 16'd0, 16'd1, 9'd0);
      send_item(lpbr_pkg::KIND_FINISH, '0, '0, '0, '0);
      send_item(lpbr_pkg::KIND_READ, '0, '0, '0, 9'd0);
      send_item(lpbr_pkg::KIND_READ, '0, '0, '0, 9'd359);
      send_item(lpbr_pkg::KIND_READ, '0, '0, '0, 9'd8);
      send_item(lpbr_pkg::KIND_READ, '0, '0, '0, 9'd1);
      send_item(lpbr_pkg::KIND_CLEAR, '0, '0, '0, '0);
      send_item(lpbr_pkg::KIND_READ, '0, '0, '0, 9'd0);
      // Fill with every bin empty: no side is found anywhere.
      write_reg(lpbr_pkg::CSR_FILL, 16'd1);
      send_item(lpbr_pkg::KIND_FINISH, '0, '0, '0, '0);
      send_item(lpbr_pkg::KIND_READ, '0, '0, '0, 9'd180);
      // Min reducer, drop filters, then a sparse fill.
      write_reg(lpbr_pkg::CSR_MODE, lpbr_pkg::RED_MIN);
      write_reg(lpbr_pkg::CSR_MIN_QUAL, 16'd100);
      write_reg(lpbr_pkg::CSR_RANGE, 16'd2000);
      send_item(lpbr_pkg::KIND_ADD, 16'd900, 16'd10, 16'd99, '0);
      send_item(lpbr_pkg::KIND_ADD, 16'd2001, 16'd10, 16'd100, '0);
      send_item(lpbr_pkg::KIND_ADD, 16'd2000, 16'd10, 16'd100, '0);
      send_item(lpbr_pkg::KIND_ADD, 16'd800, 16'd20, 16'hFFFF, '0);
      send_item(lpbr_pkg::KIND_FINISH, '0, '0, '0, '0);
      send_item(lpbr_pkg::KIND_READ, '0, '0, '0, 9'd15);
      send_item(lpbr_pkg::KIND_READ, '0, '0, '0, 9'd200);

      // Hold off until every read has come back.
      start = 1'b0;
      while (pending_reads != 0) @(negedge clock);

      // Random frames across register settings, extremes included.
      frames = 0;
      repeat (6) begin
         write_reg(lpbr_pkg::CSR_MODE,
                   frames < 4 ? 16'(frames) : 16'($urandom_range(0, 3)));
         case (frames % 3)
            0: write_reg(lpbr_pkg::CSR_MIN_QUAL, 16'd0);
            1: write_reg(lpbr_pkg::CSR_MIN_QUAL, 16'hFFFF);
            default: write_reg(lpbr_pkg::CSR_MIN_QUAL, 16'($urandom_range(0, 40000)));
         endcase
         case (frames % 3)
            0: write_reg(lpbr_pkg::CSR_RANGE, 16'd0);
            1: write_reg(lpbr_pkg::CSR_RANGE, 16'hFFFF);
            default: write_reg(lpbr_pkg::CSR_RANGE, 16'($urandom_range(500, 3000)));
         endcase
         write_reg(lpbr_pkg::CSR_FILL, 16'(frames % 2));
         no_gaps = (frames == 2);
         run_frame(80);
         frames++;
      end

      // Drain and give the verdict.
      wait_idle();
      repeat (20) @(negedge clock);
      if (mismatch_total == 0 && pending_reads == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
